// File: design/wws_pkg.sv
// Package for the weighted window smoother: widths, constants, register
// indices and the request types shared by the tap cells, metrics and top level.
// Depends on nothing.
package wws_pkg;

    localparam int MAX_HALF_WIDTH = 2;
    localparam int WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1;
    localparam int FILL_MAX       = MAX_HALF_WIDTH + 1;
    localparam int FILL_W         = $clog2(FILL_MAX + 1);
    localparam int AGE_W          = $clog2(MAX_HALF_WIDTH + 1);
    localparam int DIST_W         = $clog2(WIN_DEPTH);
    localparam int HW_W           = 2;

    // INTERVALS is kept a power of two so that the mean is a plain shift.
    localparam int INTERVALS      = 128;
    localparam int INTERVALS_LOG2 = $clog2(INTERVALS);

    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W + 1;
    localparam int SUM_W      = PROD_W + $clog2(WIN_DEPTH);
    localparam int FRAC_SHIFT = 16;
    localparam int ROUND_BIAS = 32768;

    localparam int ACC_W    = 27;
    localparam int CM_W     = 16;
    localparam int CRIT_W   = 17;
    localparam int LAMBDA_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ACC_W-1:0]    ACC_MAX    = '1;
    localparam logic [CM_W-1:0]     CM_MAX     = '1;
    localparam logic [CRIT_W-1:0]   CRIT_MAX   = '1;
    localparam logic [LAMBDA_W-1:0] LAMBDA_MAX = 4'd10;

    // Criterion: (lt*noise + (10-lt)*cm*10000) / 100000, the division done as a
    // shift by 5 followed by an exact reciprocal multiply for 3125.
    localparam int SCALE_W    = 14;
    localparam logic [SCALE_W-1:0] CLOSE_SCALE = 14'd10000;
    localparam int SCALED_W   = CM_W + SCALE_W;
    localparam int NMIX_W     = LAMBDA_W + ACC_W;
    localparam int MIX_W      = 34;
    localparam int PRE_SHIFT  = 5;
    localparam int DIV_W      = MIX_W - PRE_SHIFT;
    localparam int RECIP_W    = 29;
    localparam logic [RECIP_W-1:0] RECIP = 29'd351843721;
    localparam int RECIP_SHIFT = 40;
    localparam int QPROD_W    = DIV_W + RECIP_W;
    localparam int QUOT_W     = QPROD_W - RECIP_SHIFT;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT_CENTER = 3'd0,
        CFG_WEIGHT_INNER  = 3'd1,
        CFG_WEIGHT_OUTER  = 3'd2,
        CFG_HALF_WIDTH    = 3'd3,
        CFG_LAMBDA_TENTHS = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       final_res;
        logic [ACC_W-1:0]           noise_sum;
        logic [CM_W-1:0]            closeness_mean;
        logic [CRIT_W-1:0]          criterion;
    } out_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic signed [SAMPLE_W-1:0] raw;
        logic                       last;
    } filt_item_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic capture;
    } cell_ctrl_t;

endpackage

// File: design/wws_tap_cell.sv
// One tap cell of the window line: holds one sample, passes it to the next
// cell on a shift and registers its weighted product. Uses wws_pkg.
module wws_tap_cell import wws_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cell_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [WEIGHT_W-1:0]        weight,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic signed [PROD_W-1:0]   product
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [PROD_W-1:0]   product_reg;
    logic signed [PROD_W-1:0]   product_next;

    assign product_next = PROD_W'(sample_reg * $signed({1'b0, weight}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (ctrl.clear) begin
            sample_reg <= '0;
        end else if (ctrl.shift) begin
            sample_reg <= sample_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            product_reg <= product_next;
        end
    end

    assign sample_out = sample_reg;
    assign product    = product_reg;

endmodule

// File: design/wws_metrics.sv
// Noise and closeness accumulation and the criterion pipeline, with the output
// register of the result channel. Uses wws_pkg.
module wws_metrics import wws_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  filt_item_t          in_item,
    input  logic [LAMBDA_W-1:0] lambda_tenths,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_item
);

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W:0] b);
        logic [ACC_W+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > {2'b00, ACC_MAX}) ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    logic signed [SAMPLE_W-1:0] prev_reg;
    logic                       have_prev_reg;
    logic [ACC_W-1:0]           noise_acc_reg;
    logic [ACC_W-1:0]           close_acc_reg;

    logic [4:0] valid_reg;
    logic [4:0] rdy;

    // Stage A: accumulators.
    logic signed [SAMPLE_W-1:0] a_filt_reg;
    logic                       a_last_reg;
    logic [ACC_W-1:0]           a_noise_reg;
    logic [ACC_W-1:0]           a_close_reg;
    // Stage B: mean and first products.
    logic signed [SAMPLE_W-1:0] b_filt_reg;
    logic                       b_last_reg;
    logic [ACC_W-1:0]           b_noise_reg;
    logic [CM_W-1:0]            b_cm_reg;
    logic [NMIX_W-1:0]          b_nmix_reg;
    logic [SCALED_W-1:0]        b_scaled_reg;
    logic [LAMBDA_W-1:0]        b_comp_reg;
    // Stage C: weighted sum.
    logic signed [SAMPLE_W-1:0] c_filt_reg;
    logic                       c_last_reg;
    logic [ACC_W-1:0]           c_noise_reg;
    logic [CM_W-1:0]            c_cm_reg;
    logic [MIX_W-1:0]           c_mix_reg;
    // Stage D: reciprocal product.
    logic signed [SAMPLE_W-1:0] d_filt_reg;
    logic                       d_last_reg;
    logic [ACC_W-1:0]           d_noise_reg;
    logic [CM_W-1:0]            d_cm_reg;
    logic [QPROD_W-1:0]         d_qprod_reg;
    // Stage E: output register.
    out_item_t                  out_reg;

    logic signed [SAMPLE_W:0]   noise_diff;
    logic signed [SAMPLE_W:0]   close_diff;
    logic [SAMPLE_W:0]          noise_abs;
    logic [SAMPLE_W:0]          close_abs;
    logic [ACC_W-1:0]           noise_next;
    logic [ACC_W-1:0]           close_next;
    logic [ACC_W-1:0]           cm_full;
    logic [CM_W-1:0]            cm_next;
    logic [LAMBDA_W-1:0]        lt;
    logic [MIX_W-1:0]           comp_mix;
    logic [QUOT_W-1:0]          quot;
    logic [CRIT_W-1:0]          crit_next;
    logic                       a_load;

    assign rdy[4]   = !valid_reg[4] || out_ready;
    assign rdy[3]   = !valid_reg[3] || rdy[4];
    assign rdy[2]   = !valid_reg[2] || rdy[3];
    assign rdy[1]   = !valid_reg[1] || rdy[2];
    assign rdy[0]   = !valid_reg[0] || rdy[1];
    assign in_ready = rdy[0];
    assign a_load   = in_valid && rdy[0];

    always_comb begin
        noise_diff = {in_item.filtered[SAMPLE_W-1], in_item.filtered}
                   - {prev_reg[SAMPLE_W-1], prev_reg};
        close_diff = {in_item.filtered[SAMPLE_W-1], in_item.filtered}
                   - {in_item.raw[SAMPLE_W-1], in_item.raw};
        noise_abs  = noise_diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-noise_diff) : noise_diff;
        close_abs  = close_diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-close_diff) : close_diff;
        noise_next = have_prev_reg ? sat_add(noise_acc_reg, (ACC_W + 1)'(noise_abs))
                                   : noise_acc_reg;
        close_next = sat_add(close_acc_reg, (ACC_W + 1)'(close_abs));

        cm_full  = a_close_reg >> INTERVALS_LOG2;
        cm_next  = (cm_full > ACC_W'(CM_MAX)) ? CM_MAX : cm_full[CM_W-1:0];
        lt       = (lambda_tenths > LAMBDA_MAX) ? LAMBDA_MAX : lambda_tenths;

        comp_mix = MIX_W'(b_comp_reg) * MIX_W'(b_scaled_reg);

        quot      = d_qprod_reg[QPROD_W-1:RECIP_SHIFT];
        crit_next = (quot > QUOT_W'(CRIT_MAX)) ? CRIT_MAX : quot[CRIT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            noise_acc_reg <= '0;
            close_acc_reg <= '0;
        end else if (a_load) begin
            if (in_item.last) begin
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
                noise_acc_reg <= '0;
                close_acc_reg <= '0;
            end else begin
                prev_reg      <= in_item.filtered;
                have_prev_reg <= 1'b1;
                noise_acc_reg <= noise_next;
                close_acc_reg <= close_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            if (rdy[1]) begin
                valid_reg[1] <= valid_reg[0];
            end
            if (rdy[2]) begin
                valid_reg[2] <= valid_reg[1];
            end
            if (rdy[3]) begin
                valid_reg[3] <= valid_reg[2];
            end
            if (rdy[4]) begin
                valid_reg[4] <= valid_reg[3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            a_filt_reg  <= in_item.filtered;
            a_last_reg  <= in_item.last;
            a_noise_reg <= noise_next;
            a_close_reg <= close_next;
        end
        if (rdy[1]) begin
            b_filt_reg   <= a_filt_reg;
            b_last_reg   <= a_last_reg;
            b_noise_reg  <= a_noise_reg;
            b_cm_reg     <= cm_next;
            b_nmix_reg   <= lt * a_noise_reg;
            b_scaled_reg <= cm_next * CLOSE_SCALE;
            b_comp_reg   <= LAMBDA_MAX - lt;
        end
        if (rdy[2]) begin
            c_filt_reg  <= b_filt_reg;
            c_last_reg  <= b_last_reg;
            c_noise_reg <= b_noise_reg;
            c_cm_reg    <= b_cm_reg;
            c_mix_reg   <= MIX_W'(b_nmix_reg) + comp_mix;
        end
        if (rdy[3]) begin
            d_filt_reg  <= c_filt_reg;
            d_last_reg  <= c_last_reg;
            d_noise_reg <= c_noise_reg;
            d_cm_reg    <= c_cm_reg;
            d_qprod_reg <= c_mix_reg[MIX_W-1:PRE_SHIFT] * RECIP;
        end
        if (rdy[4]) begin
            out_reg.filtered       <= d_filt_reg;
            out_reg.final_res      <= d_last_reg;
            out_reg.noise_sum      <= d_last_reg ? d_noise_reg : '0;
            out_reg.closeness_mean <= d_last_reg ? d_cm_reg : '0;
            out_reg.criterion      <= d_last_reg ? crit_next : '0;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_item  = out_reg;

endmodule

// File: design/weighted_window_smoother_metrics_top.sv
// Weighted window smoother top level: configuration registers, the tap request
// sequencer, the row of tap cells and the rounding stage; uses wws_pkg.
// Path: tap cells, the s1 and s2 registers, then the metrics stages A to E.
// Throughput: one sample per clock unless stalled; a frame end giving k results
// issues k tap requests, one per clock unless stalled, before the next sample.
// Reset (synchronous, aresetn low) clears the window, counters and accumulators.
module weighted_window_smoother_metrics_top import wws_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic signed [SUM_W-1:0] FILT_HI = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] FILT_LO = -SUM_W'(2 ** (SAMPLE_W - 1));

    logic [WEIGHT_W-1:0] weight_center_reg;
    logic [WEIGHT_W-1:0] weight_inner_reg;
    logic [WEIGHT_W-1:0] weight_outer_reg;
    logic [HW_W-1:0]     half_width_reg;
    logic [LAMBDA_W-1:0] lambda_reg;

    logic             pend_valid_reg, pend_valid_next;
    logic [AGE_W-1:0] pend_age_reg, pend_age_next;
    logic             pend_last_reg, pend_last_next;
    logic             pend_flush_reg, pend_flush_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic              s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_raw_reg;
    logic              s1_last_reg;
    logic              s2_valid_reg;
    filt_item_t        s2_item_reg;

    logic              s1_ready, s2_ready, met_ready;
    logic              in_accept, issue;
    logic [HW_W-1:0]   eff_h;
    logic [FILL_W-1:0] fill_inc;
    logic [AGE_W-1:0]  flush_age;
    logic signed [SAMPLE_W-1:0] raw_sel;
    cell_ctrl_t        cell_ctrl;

    logic signed [SAMPLE_W-1:0] cell_sample [WIN_DEPTH];
    logic signed [PROD_W-1:0]   cell_prod   [WIN_DEPTH];
    logic [WEIGHT_W-1:0]        cell_weight [WIN_DEPTH];

    logic signed [SUM_W-1:0]    tap_sum;
    logic signed [SUM_W-1:0]    rounded;
    logic signed [SAMPLE_W-1:0] filt_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_center_reg <= '1;
            weight_inner_reg  <= '0;
            weight_outer_reg  <= '0;
            half_width_reg    <= HW_W'(1);
            lambda_reg        <= LAMBDA_W'(5);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WEIGHT_CENTER: begin
                    weight_center_reg <= cfg_data[WEIGHT_W-1:0];
                end
                CFG_WEIGHT_INNER: begin
                    weight_inner_reg <= cfg_data[WEIGHT_W-1:0];
                end
                CFG_WEIGHT_OUTER: begin
                    weight_outer_reg <= cfg_data[WEIGHT_W-1:0];
                end
                CFG_HALF_WIDTH: begin
                    half_width_reg <= cfg_data[HW_W-1:0];
                end
                CFG_LAMBDA_TENTHS: begin
                    lambda_reg <= cfg_data[LAMBDA_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign eff_h = (half_width_reg == '0) ? HW_W'(1)
                 : (half_width_reg > HW_W'(MAX_HALF_WIDTH)) ? HW_W'(MAX_HALF_WIDTH)
                 : half_width_reg;

    assign s2_ready  = !s2_valid_reg || met_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = !pend_valid_reg || (s1_ready && !pend_flush_reg);
    assign in_accept = s_valid && s_ready;
    assign issue     = pend_valid_reg && s1_ready;
    assign fill_inc  = (fill_reg < FILL_W'(FILL_MAX)) ? fill_reg + 1'b1 : fill_reg;
    assign flush_age = (FILL_W'(eff_h) < fill_inc) ? AGE_W'(eff_h)
                                                   : AGE_W'(fill_inc - 1'b1);

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_age_next   = pend_age_reg;
        pend_last_next  = pend_last_reg;
        pend_flush_next = pend_flush_reg;
        fill_next       = fill_reg;
        cell_ctrl       = '0;
        if (issue) begin
            if (pend_flush_reg && pend_age_reg != '0) begin
                pend_age_next  = pend_age_reg - 1'b1;
                pend_last_next = (pend_age_reg == AGE_W'(1));
            end else begin
                pend_valid_next = 1'b0;
                if (pend_flush_reg) begin
                    fill_next       = '0;
                    cell_ctrl.clear = 1'b1;
                end
            end
        end
        if (in_accept) begin
            cell_ctrl.shift = 1'b1;
            fill_next       = fill_inc;
            if (s_item.frame_end) begin
                pend_valid_next = 1'b1;
                pend_age_next   = flush_age;
                pend_last_next  = (flush_age == '0);
                pend_flush_next = 1'b1;
            end else if (FILL_W'(eff_h) < fill_inc) begin
                pend_valid_next = 1'b1;
                pend_age_next   = AGE_W'(eff_h);
                pend_last_next  = 1'b0;
                pend_flush_next = 1'b0;
            end
        end
        cell_ctrl.capture = s1_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_age_reg   <= '0;
            pend_last_reg  <= 1'b0;
            pend_flush_reg <= 1'b0;
            fill_reg       <= '0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            pend_age_reg   <= pend_age_next;
            pend_last_reg  <= pend_last_next;
            pend_flush_reg <= pend_flush_next;
            fill_reg       <= fill_next;
        end
    end

    always_comb begin
        logic [DIST_W-1:0] age_ext;
        logic [DIST_W-1:0] tap_dist;
        age_ext = DIST_W'(pend_age_reg);
        for (int d = 0; d < WIN_DEPTH; d++) begin
            tap_dist = (age_ext >= DIST_W'(d)) ? age_ext - DIST_W'(d)
                                               : DIST_W'(d) - age_ext;
            if (tap_dist == '0) begin
                cell_weight[d] = weight_center_reg;
            end else if (tap_dist > DIST_W'(eff_h)) begin
                cell_weight[d] = '0;
            end else if (tap_dist == DIST_W'(1)) begin
                cell_weight[d] = weight_inner_reg;
            end else begin
                cell_weight[d] = weight_outer_reg;
            end
        end
        raw_sel = cell_sample[0];
        for (int d = 1; d <= MAX_HALF_WIDTH; d++) begin
            if (pend_age_reg == AGE_W'(d)) begin
                raw_sel = cell_sample[d];
            end
        end
    end

    for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
        logic signed [SAMPLE_W-1:0] left_sample;
        if (g == 0) begin : g_head
            assign left_sample = s_item.sample;
        end else begin : g_body
            assign left_sample = cell_sample[g-1];
        end
        wws_tap_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .sample_in  (left_sample),
            .weight     (cell_weight[g]),
            .sample_out (cell_sample[g]),
            .product    (cell_prod[g])
        );
    end

    always_comb begin
        tap_sum = '0;
        for (int d = 0; d < WIN_DEPTH; d++) begin
            tap_sum = tap_sum + SUM_W'(cell_prod[d]);
        end
        rounded = (tap_sum + SUM_W'(ROUND_BIAS)) >>> FRAC_SHIFT;
        if (rounded > FILT_HI) begin
            filt_sat = FILT_HI[SAMPLE_W-1:0];
        end else if (rounded < FILT_LO) begin
            filt_sat = FILT_LO[SAMPLE_W-1:0];
        end else begin
            filt_sat = rounded[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= issue;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_raw_reg  <= raw_sel;
            s1_last_reg <= pend_last_reg;
        end
        if (s2_ready) begin
            s2_item_reg.filtered <= filt_sat;
            s2_item_reg.raw      <= s1_raw_reg;
            s2_item_reg.last     <= s1_last_reg;
        end
    end

    wws_metrics u_metrics (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s2_valid_reg),
        .in_ready      (met_ready),
        .in_item       (s2_item_reg),
        .lambda_tenths (lambda_reg),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_item      (m_item)
    );

    a_flush_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && pend_flush_reg |-> !s_ready)
        else $error("sample accepted while a frame flush is still issuing");

    a_frame_end_flushes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.frame_end |=> pend_valid_reg && pend_flush_reg)
        else $error("frame end did not start a flush");

    a_metrics_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.final_res |-> m_item.noise_sum == '0
            && m_item.closeness_mean == '0 && m_item.criterion == '0)
        else $error("metrics present on a non-final result");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(FILL_MAX))
        else $error("fill count beyond its limit");

endmodule
